// ===== rtl/sfp_pkg.sv =====
// shared types and constants of the byte-sum checksum frame parser
// no dependencies; used by sfp_front, sfp_cmd_queue, sfp_back and the top level
package sfp_pkg;

   localparam logic [7:0] START_BYTE = 8'h42;
   localparam int         WORD_MAX   = 15;
   localparam int         IDX_W      = 4;
   localparam int         ADDR_W     = IDX_W + 1;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   // number of packed words in a frame, capped at WORD_MAX
   function automatic int word_count(input int frame_bytes);
      int n;
      n = (frame_bytes - 2) / 2;
      return (n > WORD_MAX) ? WORD_MAX : n;
   endfunction

   // closed frame handed from front to back
   typedef struct packed {
      logic err;
      logic bank;
   } cmd_type;

   // word store write from the front
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [15:0]       data;
   } wr_type;

   typedef struct packed {
      logic             status;
      logic [IDX_W-1:0] word_index;
      logic [15:0]      word_value;
      logic             last;
   } rsp_type;

endpackage

// ===== rtl/sensor_frame_parser_sum_check.sv =====
// top level of the byte-sum checksum frame parser
// depends on sfp_pkg, sfp_front, sfp_cmd_queue and sfp_back
//
// usage:
//  - input side is a queue write port: a byte transfers when push is high and full
//    is low; one byte can transfer every cycle
//  - result side is a queue read port: the oldest result sits on rsp_* while empty
//    is low and transfers when pop is high
//  - the front hunts for the 0x42 start byte, sums and packs the frame on the fly
//    and hands each closed frame to a two-entry frame queue
//  - the back reads the frame's words out of a two-bank word store, one word per
//    cycle while the result queue has room, into a four-entry result queue
//  - the closing byte passes the frame queue, the read stage and the result queue
//    before the first result shows on rsp_*; a good frame then drains word by word
//  - the one-byte input port sets the pace of frames; the back issues one store
//    read per word of a good frame and a single error result per bad frame
//  - a stalled receiver backs up the result queue, then the frame queue; full rises
//    once two closed frames wait and holds until the older one has been read out
//  - reset (synchronous) empties both queues and returns the front to hunting
module sensor_frame_parser_sum_check #(
   parameter int FRAME_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_rx_byte,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_status,
   output logic [3:0]  rsp_word_index,
   output logic [15:0] rsp_word_value,
   output logic        rsp_last
);

   logic             byte_valid;
   sfp_pkg::wr_type  store_wr;
   logic             cmd_push;
   sfp_pkg::cmd_type cmd_in;
   logic             cmd_pop;
   logic             cmd_valid;
   sfp_pkg::cmd_type cmd_head;
   sfp_pkg::rsp_type rsp;

   // a byte transfer
   assign byte_valid = push && !full;

   sfp_front #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .wr         (store_wr),
      .cmd_push   (cmd_push),
      .cmd        (cmd_in)
   );

   // full also keeps the front off the bank that the back still reads
   sfp_cmd_queue u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd_in),
      .pop        (cmd_pop),
      .full       (full),
      .head_valid (cmd_valid),
      .head_cmd   (cmd_head)
   );

   sfp_back #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .wr        (store_wr),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp       (rsp)
   );

   assign rsp_status     = rsp.status;
   assign rsp_word_index = rsp.word_index;
   assign rsp_word_value = rsp.word_value;
   assign rsp_last       = rsp.last;

endmodule

// ===== rtl/sfp_front.sv =====
// front part: start byte hunt, byte sum, word packing and checksum compare
// depends on sfp_pkg; writes the word store in sfp_back, pushes into sfp_cmd_queue
module sfp_front #(
   parameter int FRAME_BYTES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             byte_valid,
   input  logic [7:0]       rx_byte,
   output sfp_pkg::wr_type  wr,
   output logic             cmd_push,
   output sfp_pkg::cmd_type cmd
);

   localparam int POS_W      = $clog2(FRAME_BYTES);
   localparam int WORD_COUNT = sfp_pkg::word_count(FRAME_BYTES);

   logic             in_frame_ff, in_frame_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      sum_ff, sum_in;
   logic [7:0]       latch_ff, latch_in;
   logic             bank_ff, bank_in;

   logic                      closing;
   logic                      is_word;
   logic [sfp_pkg::IDX_W-1:0] word_idx;
   logic [15:0]               pair;

   assign closing  = (pos_ff == POS_W'(FRAME_BYTES - 1));
   assign pair     = {latch_ff, rx_byte};
   assign word_idx = sfp_pkg::IDX_W'((pos_ff - POS_W'(3)) >> 1);
   assign is_word  = (pos_ff >= POS_W'(3)) && pos_ff[0]
                     && (pos_ff <= POS_W'(2 * WORD_COUNT + 1));

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      sum_in      = sum_ff;
      latch_in    = latch_ff;
      bank_in     = bank_ff;
      wr.en       = 1'b0;
      wr.addr     = {bank_ff, word_idx};
      wr.data     = pair;
      cmd_push    = 1'b0;
      cmd.err     = (pair != sum_ff);
      cmd.bank    = bank_ff;
      if (byte_valid) begin
         if (!in_frame_ff) begin
            if (rx_byte == sfp_pkg::START_BYTE) begin
               in_frame_in = 1'b1;
               sum_in      = 16'(rx_byte);
               latch_in    = rx_byte;
               pos_in      = POS_W'(1);
            end
         end else begin
            // every byte but the last two (the checksum) goes into the sum
            if (pos_ff < POS_W'(FRAME_BYTES - 2)) begin
               sum_in = sum_ff + 16'(rx_byte);
            end
            wr.en    = is_word;
            latch_in = rx_byte;
            if (closing) begin
               in_frame_in = 1'b0;
               pos_in      = '0;
               cmd_push    = 1'b1;
               bank_in     = ~bank_ff;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         sum_ff      <= '0;
         latch_ff    <= '0;
         bank_ff     <= 1'b0;
      end else begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         sum_ff      <= sum_in;
         latch_ff    <= latch_in;
         bank_ff     <= bank_in;
      end
   end

endmodule

// ===== rtl/sfp_cmd_queue.sv =====
// two-entry queue of closed frames between front and back
// depends on sfp_pkg
module sfp_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sfp_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             head_valid,
   output sfp_pkg::cmd_type head_cmd
);

   sfp_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sfp_back.sv =====
// back part: two-bank word store, word emitter and result queue
// depends on sfp_pkg; fed by sfp_front (store writes) and sfp_cmd_queue
module sfp_back #(
   parameter int FRAME_BYTES = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  sfp_pkg::wr_type  wr,
   input  logic             cmd_valid,
   input  sfp_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             rsp_pop,
   output logic             rsp_empty,
   output sfp_pkg::rsp_type rsp
);

   localparam int WORD_COUNT = sfp_pkg::word_count(FRAME_BYTES);
   localparam int DEPTH      = 2 ** sfp_pkg::ADDR_W;

   // word store, one bank per frame in flight
   logic [15:0] store_mem [DEPTH];
   logic [15:0] rd_data_ff;

   logic [sfp_pkg::IDX_W-1:0] idx_ff, idx_in;

   // read stage
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_err_ff, s1_err_in;
   logic                      s1_last_ff, s1_last_in;
   logic [sfp_pkg::IDX_W-1:0] s1_idx_ff, s1_idx_in;

   // result queue
   sfp_pkg::rsp_type rq_ff [4];
   logic [1:0]       rq_wr_ff, rq_wr_in;
   logic [1:0]       rq_rd_ff, rq_rd_in;
   logic [2:0]       rq_count_ff, rq_count_in;
   logic             rq_pop;
   sfp_pkg::rsp_type s1_rsp;

   logic issue;
   logic last_word;

   assign issue     = cmd_valid && ((rq_count_ff + 3'(s1_valid_ff)) <= 3'd3);
   assign last_word = (idx_ff == sfp_pkg::IDX_W'(WORD_COUNT - 1));
   assign cmd_pop   = issue && (cmd.err || last_word);

   always_comb begin
      idx_in      = idx_ff;
      s1_valid_in = issue;
      s1_err_in   = cmd.err;
      s1_idx_in   = idx_ff;
      s1_last_in  = cmd.err || last_word;
      if (issue && !cmd.err) begin
         idx_in = last_word ? '0 : idx_ff + sfp_pkg::IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= store_mem[{cmd.bank, idx_ff}];
   end

   always_comb begin
      s1_rsp.status     = s1_err_ff ? sfp_pkg::STATUS_ERROR : sfp_pkg::STATUS_OK;
      s1_rsp.word_index = s1_err_ff ? '0 : s1_idx_ff;
      s1_rsp.word_value = s1_err_ff ? '0 : rd_data_ff;
      s1_rsp.last       = s1_last_ff;
   end

   assign rsp_empty = (rq_count_ff == 3'd0);
   assign rsp       = rq_ff[rq_rd_ff];
   assign rq_pop    = rsp_pop && !rsp_empty;

   always_comb begin
      rq_wr_in    = s1_valid_ff ? rq_wr_ff + 2'd1 : rq_wr_ff;
      rq_rd_in    = rq_pop ? rq_rd_ff + 2'd1 : rq_rd_ff;
      rq_count_in = rq_count_ff + 3'(s1_valid_ff) - 3'(rq_pop);
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rq_ff[rq_wr_ff] <= s1_rsp;
      end
      s1_err_ff  <= s1_err_in;
      s1_idx_ff  <= s1_idx_in;
      s1_last_ff <= s1_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         s1_valid_ff <= 1'b0;
         rq_wr_ff    <= '0;
         rq_rd_ff    <= '0;
         rq_count_ff <= '0;
      end else begin
         idx_ff      <= idx_in;
         s1_valid_ff <= s1_valid_in;
         rq_wr_ff    <= rq_wr_in;
         rq_rd_ff    <= rq_rd_in;
         rq_count_ff <= rq_count_in;
      end
   end

endmodule
